FILE: hdl/blp_pkg.sv
// Shared types, constants and tables of the burst length predictor.
`default_nettype none
package blp_pkg;

    localparam int TIME_W = 48;
    localparam int VAL_W  = 48;
    localparam int FRAC_W = 8;
    localparam int OUT_W  = 40;
    localparam int CFG_W  = 32;
    localparam int DIVQ_W = TIME_W + 8;
    localparam int PROD_W = 65;
    localparam int ACC_W  = 66;

    localparam logic [2:0] REQ_START = 3'd0;
    localparam logic [2:0] REQ_STOP  = 3'd1;
    localparam logic [2:0] REQ_INTR  = 3'd2;
    localparam logic [2:0] REQ_QUERY = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    localparam logic [2:0] CFG_MERGE_GAP  = 3'd0;
    localparam logic [2:0] CFG_VALID_TIME = 3'd1;
    localparam logic [2:0] CFG_HALF_LIFE  = 3'd2;
    localparam logic [2:0] CFG_ALPHA      = 3'd3;
    localparam logic [2:0] CFG_COLD_START = 3'd4;

    // Q32 value of 2^-(2^k/256)
    function automatic logic [31:0] pow_q32(input logic [2:0] k);
        logic [31:0] v;
        case (k)
            3'd0: v = 32'd4283353945;
            3'd1: v = 32'd4271771996;
            3'd2: v = 32'd4248701965;
            3'd3: v = 32'd4202935003;
            3'd4: v = 32'd4112874773;
            3'd5: v = 32'd3938502376;
            3'd6: v = 32'd3611622603;
            default: v = 32'd3037000500;
        endcase
        return v;
    endfunction

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_START, OP_STOP_END, OP_INTR, OP_CLEAR, OP_STALE,
        OP_LOADD, OP_DIV_LOAD, OP_DIV_STEP, OP_POW_MUL, OP_POW_RND, OP_POW_SKIP,
        OP_FACT, OP_HMUL_LO, OP_HMUL_HI, OP_HSUM, OP_PEAK, OP_EMA_A_LO,
        OP_EMA_A_HI, OP_EMA_B_LO, OP_EMA_B_HI, OP_EMA_SUM, OP_ADD_FIN, OP_PRED,
        OP_OUT
    } t_dp_op;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_STALE, ST_LOADD, ST_DCHK, ST_DIV, ST_POW,
        ST_POWR, ST_HLO, ST_HHI, ST_HSUM, ST_PEAK, ST_TAIL, ST_EA_HI, ST_EB_LO,
        ST_EB_HI, ST_ESUM, ST_AFIN, ST_STOPEND, ST_DONE
    } t_state;

    typedef struct packed {
        t_dp_op op;
        logic   sel;
        logic   in_ready;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       burst_open;
        logic       decay_go;
        logic       div_last;
        logic       pow_bit;
        logic       pow_done;
        logic       out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

FILE: hdl/blp_req_if.sv
// Request channel: event type and timestamp.
`default_nettype none
interface blp_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [47:0] timestamp_us;
    modport source (output valid, req_type, timestamp_us, input ready);
    modport sink (input valid, req_type, timestamp_us, output ready);
endinterface
`default_nettype wire

FILE: hdl/blp_res_if.sv
// Result channel: predictions and activity flags.
`default_nettype none
interface blp_res_if;
    logic        valid;
    logic        ready;
    logic [39:0] pred_burst_us;
    logic [39:0] pred_merged_us;
    logic        burst_active;
    logic        merged_active;
    modport source (output valid, pred_burst_us, pred_merged_us, burst_active,
                    merged_active, input ready);
    modport sink (input valid, pred_burst_us, pred_merged_us, burst_active,
                  merged_active, output ready);
endinterface
`default_nettype wire

FILE: hdl/blp_datapath.sv
// Datapath: event state, trackers, divider, shared multiplier and result register.
`default_nettype none
module blp_datapath (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  blp_pkg::t_dp_cmd      i_cmd,
    output blp_pkg::t_dp_sts      o_sts,
    input  wire  [2:0]            i_req_type,
    input  wire  [47:0]           i_timestamp_us,
    input  wire                   i_cfg_we,
    input  wire  [2:0]            i_cfg_idx,
    input  wire  [31:0]           i_cfg_data,
    input  wire                   i_out_ready,
    output logic                  o_out_valid,
    output logic [39:0]           o_pred_burst_us,
    output logic [39:0]           o_pred_merged_us,
    output logic                  o_burst_active,
    output logic                  o_merged_active
);
    import blp_pkg::*;

    logic [CFG_W-1:0] r_gap, r_vtime, r_hl;
    logic [15:0]      r_alpha;
    logic [7:0]       r_csc;

    logic [2:0]        r_req;
    logic [TIME_W-1:0] r_now;
    logic              r_bopen, r_mopen, r_mend_v;
    logic [TIME_W-1:0] r_bbeg, r_mbeg, r_mend;

    logic [VAL_W-1:0]  r_avg [2];
    logic [VAL_W-1:0]  r_peak [2];
    logic [7:0]        r_smp [2];
    logic [TIME_W-1:0] r_tsmp [2];
    logic [TIME_W-1:0] r_tdec [2];

    logic [VAL_W-1:0]  r_d;
    logic [31:0]       r_rem;
    logic [DIVQ_W-1:0] r_quo;
    logic [5:0]        r_cnt;
    logic [3:0]        r_k;
    logic [32:0]       r_fac;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic [OUT_W-1:0]  r_pb, r_pm;
    logic              r_ovalid;

    logic              sel;
    logic [VAL_W-1:0]  cur_a, cur_p, h, shr, dec_p, pred_v, avg_new;
    logic              p_ge;
    logic [TIME_W-1:0] el, mgap_el, beg_el, smp_el;
    logic [32:0]       div_t;
    logic              div_ge;
    logic [TIME_W-1:0] quo_n;
    logic [7:0]        quo_f;
    logic              n_big;
    logic [5:0]        sh;
    logic [32:0]       mul_x;
    logic [31:0]       mul_y;
    logic [PROD_W-1:0] w_prod;
    logic [16:0]       beta;
    logic [88:0]       prod_sh;

    assign sel    = i_cmd.sel;
    assign cur_a  = r_avg[sel];
    assign cur_p  = r_peak[sel];
    assign p_ge   = cur_p >= cur_a;
    assign h      = p_ge ? cur_p - cur_a : cur_a - cur_p;
    assign el     = r_now - r_tdec[sel];
    assign mgap_el = (r_now > r_mend) ? r_now - r_mend : '0;
    assign beg_el = sel ? ((r_now > r_mbeg) ? r_now - r_mbeg : '0)
                        : ((r_now > r_bbeg) ? r_now - r_bbeg : '0);
    assign smp_el = (r_now > r_tsmp[sel]) ? r_now - r_tsmp[sel] : '0;
    assign div_t  = {r_rem, r_quo[DIVQ_W-1]};
    assign div_ge = div_t >= {1'b0, r_hl};
    assign quo_n  = r_quo[DIVQ_W-1:8];
    assign quo_f  = r_quo[7:0];
    assign n_big  = quo_n >= TIME_W'(48);
    assign sh     = 6'd16 + quo_n[5:0];
    assign shr    = n_big ? '0 : VAL_W'(r_acc >> sh);
    assign dec_p  = p_ge ? cur_a + shr : cur_a - shr;
    assign beta   = 17'h10000 - {1'b0, r_alpha};
    assign w_prod = {32'b0, mul_x} * {33'b0, mul_y};
    assign prod_sh = {r_prod, 24'b0};
    assign avg_new = (r_smp[sel] == 8'd0) ? r_d : r_acc[63:16];

    always_comb begin
        if (r_smp[sel] == 8'd0) begin
            pred_v = '0;
        end else if (r_smp[sel] < r_csc) begin
            pred_v = cur_p;
        end else begin
            pred_v = cur_a + ((cur_p > cur_a) ? (cur_p - cur_a) >> 1 : '0);
        end
    end

    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (i_cmd.op)
            OP_POW_MUL: begin
                mul_x = r_fac;
                mul_y = pow_q32(r_k[2:0]);
            end
            OP_HMUL_LO: begin
                mul_x = {16'b0, r_fac[16:0]};
                mul_y = {8'b0, h[23:0]};
            end
            OP_HMUL_HI: begin
                mul_x = {16'b0, r_fac[16:0]};
                mul_y = {8'b0, h[47:24]};
            end
            OP_EMA_A_LO: begin
                mul_x = {17'b0, r_alpha};
                mul_y = {8'b0, r_d[23:0]};
            end
            OP_EMA_A_HI: begin
                mul_x = {17'b0, r_alpha};
                mul_y = {8'b0, r_d[47:24]};
            end
            OP_EMA_B_LO: begin
                mul_x = {16'b0, beta};
                mul_y = {8'b0, cur_a[23:0]};
            end
            OP_EMA_B_HI: begin
                mul_x = {16'b0, beta};
                mul_y = {8'b0, cur_a[47:24]};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.req        = r_req;
        o_sts.burst_open = r_bopen;
        o_sts.decay_go   = (r_smp[sel] != 8'd0) && (r_hl != '0) && (r_now > r_tdec[sel]);
        o_sts.div_last   = r_cnt == 6'(DIVQ_W - 1);
        o_sts.pow_bit    = quo_f[r_k[2:0]];
        o_sts.pow_done   = r_k == 4'd8;
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap   <= 32'd1000;
            r_vtime <= 32'd3000000;
            r_hl    <= 32'd500000;
            r_alpha <= 16'd19661;
            r_csc   <= 8'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MERGE_GAP:  r_gap   <= i_cfg_data;
                CFG_VALID_TIME: r_vtime <= i_cfg_data;
                CFG_HALF_LIFE:  r_hl    <= i_cfg_data;
                CFG_ALPHA:      r_alpha <= i_cfg_data[15:0];
                CFG_COLD_START: r_csc   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // event and tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bopen  <= 1'b0;
            r_mopen  <= 1'b0;
            r_mend_v <= 1'b0;
            r_bbeg   <= '0;
            r_mbeg   <= '0;
            r_mend   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_avg[i]  <= '0;
                r_peak[i] <= '0;
                r_smp[i]  <= '0;
                r_tsmp[i] <= '0;
                r_tdec[i] <= '0;
            end
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                OP_START: begin
                    if (!r_bopen) begin
                        r_bopen <= 1'b1;
                        r_bbeg  <= r_now;
                        if (!r_mopen || !r_mend_v || mgap_el > {16'b0, r_gap}) begin
                            r_mopen  <= 1'b1;
                            r_mbeg   <= r_now;
                            r_mend_v <= 1'b0;
                        end
                    end
                end
                OP_STOP_END: begin
                    if (r_bopen) begin
                        r_mend   <= r_now;
                        r_mend_v <= 1'b1;
                    end
                    r_bopen <= 1'b0;
                end
                OP_INTR: begin
                    r_bopen  <= 1'b0;
                    r_mopen  <= 1'b0;
                    r_mend_v <= 1'b0;
                end
                OP_CLEAR: begin
                    r_bopen  <= 1'b0;
                    r_mopen  <= 1'b0;
                    r_mend_v <= 1'b0;
                    for (int i = 0; i < 2; i++) begin
                        r_avg[i]  <= '0;
                        r_peak[i] <= '0;
                        r_smp[i]  <= '0;
                        r_tsmp[i] <= '0;
                        r_tdec[i] <= '0;
                    end
                end
                OP_STALE: begin
                    if (r_smp[sel] != 8'd0 && smp_el > {16'b0, r_vtime}) begin
                        r_avg[sel]  <= '0;
                        r_peak[sel] <= '0;
                        r_smp[sel]  <= '0;
                        r_tsmp[sel] <= '0;
                        r_tdec[sel] <= '0;
                    end
                end
                OP_PEAK: begin
                    r_peak[sel] <= dec_p;
                    r_tdec[sel] <= r_now;
                end
                OP_ADD_FIN: begin
                    r_avg[sel]  <= avg_new;
                    if (r_smp[sel] != 8'd255) begin
                        r_smp[sel] <= r_smp[sel] + 8'd1;
                    end
                    if (r_d > cur_p) begin
                        r_peak[sel] <= r_d;
                    end
                    r_tsmp[sel] <= r_now;
                    r_tdec[sel] <= r_now;
                end
                OP_OUT: begin
                    r_ovalid <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_req <= i_req_type;
                r_now <= i_timestamp_us;
                r_pb  <= '0;
                r_pm  <= '0;
            end
            OP_LOADD: begin
                r_d <= (beg_el > TIME_W'((2 ** (VAL_W - FRAC_W)) - 1)) ? '1
                       : VAL_W'(beg_el << FRAC_W);
            end
            OP_DIV_LOAD: begin
                r_rem <= '0;
                r_quo <= {el, 8'b0};
                r_cnt <= '0;
                r_k   <= '0;
                r_fac <= 33'h1_0000_0000;
            end
            OP_DIV_STEP: begin
                r_rem <= div_ge ? 32'(div_t - {1'b0, r_hl}) : div_t[31:0];
                r_quo <= {r_quo[DIVQ_W-2:0], div_ge};
                r_cnt <= r_cnt + 6'd1;
            end
            OP_POW_MUL: begin
                r_prod <= w_prod;
            end
            OP_POW_RND: begin
                r_fac <= 33'((r_prod + PROD_W'(33'h0_8000_0000)) >> 32);
                r_k   <= r_k + 4'd1;
            end
            OP_POW_SKIP: begin
                r_k <= r_k + 4'd1;
            end
            OP_FACT: begin
                r_fac <= (r_fac + 33'h8000) >> 16;
            end
            OP_HMUL_LO: begin
                r_prod <= w_prod;
                r_acc  <= '0;
            end
            OP_HMUL_HI, OP_EMA_A_HI, OP_EMA_B_HI: begin
                r_prod <= w_prod;
                r_acc  <= r_acc + ACC_W'(r_prod);
            end
            OP_HSUM, OP_EMA_SUM: begin
                r_acc <= r_acc + prod_sh[ACC_W-1:0];
            end
            OP_EMA_A_LO: begin
                r_prod <= w_prod;
                r_acc  <= ACC_W'(32768);
            end
            OP_EMA_B_LO: begin
                r_prod <= w_prod;
                r_acc  <= r_acc + prod_sh[ACC_W-1:0];
            end
            OP_PRED: begin
                if (sel) begin
                    r_pm <= pred_v[VAL_W-1:FRAC_W];
                end else begin
                    r_pb <= pred_v[VAL_W-1:FRAC_W];
                end
            end
            OP_OUT: begin
                o_pred_burst_us  <= r_pb;
                o_pred_merged_us <= r_pm;
                o_burst_active   <= r_bopen;
                o_merged_active  <= r_mopen;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_ovalid;

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV_STEP) |=> (r_rem < r_hl))
        else $error("divider remainder not below half-life");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(i_cmd.op) == OP_OUT))
        else $error("result raised without a load");
    a_fac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FACT) |=> (r_fac <= 33'h10000))
        else $error("decay factor above one");

endmodule
`default_nettype wire

FILE: hdl/blp_ctrl.sv
// Controller: sequences each item's work over the datapath.
`default_nettype none
module blp_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  blp_pkg::t_dp_sts i_sts,
    output blp_pkg::t_dp_cmd o_cmd
);
    import blp_pkg::*;

    t_state r_state, n_state;
    logic   r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_sel          = r_sel;
        o_cmd.op       = OP_NONE;
        o_cmd.sel      = r_sel;
        o_cmd.in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_sel = 1'b0;
                case (i_sts.req)
                    REQ_START: begin
                        o_cmd.op = OP_START;
                        n_state  = ST_DONE;
                    end
                    REQ_STOP: begin
                        n_state = i_sts.burst_open ? ST_LOADD : ST_STOPEND;
                    end
                    REQ_INTR: begin
                        o_cmd.op = OP_INTR;
                        n_state  = ST_DONE;
                    end
                    REQ_QUERY: n_state = ST_STALE;
                    REQ_CLEAR: begin
                        o_cmd.op = OP_CLEAR;
                        n_state  = ST_DONE;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_STALE: begin
                o_cmd.op = OP_STALE;
                n_state  = ST_DCHK;
            end
            ST_LOADD: begin
                o_cmd.op = OP_LOADD;
                n_state  = ST_DCHK;
            end
            ST_DCHK: begin
                if (i_sts.decay_go) begin
                    o_cmd.op = OP_DIV_LOAD;
                    n_state  = ST_DIV;
                end else begin
                    n_state = ST_TAIL;
                end
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_sts.div_last) begin
                    n_state = ST_POW;
                end
            end
            ST_POW: begin
                if (i_sts.pow_done) begin
                    o_cmd.op = OP_FACT;
                    n_state  = ST_HLO;
                end else if (i_sts.pow_bit) begin
                    o_cmd.op = OP_POW_MUL;
                    n_state  = ST_POWR;
                end else begin
                    o_cmd.op = OP_POW_SKIP;
                end
            end
            ST_POWR: begin
                o_cmd.op = OP_POW_RND;
                n_state  = ST_POW;
            end
            ST_HLO: begin
                o_cmd.op = OP_HMUL_LO;
                n_state  = ST_HHI;
            end
            ST_HHI: begin
                o_cmd.op = OP_HMUL_HI;
                n_state  = ST_HSUM;
            end
            ST_HSUM: begin
                o_cmd.op = OP_HSUM;
                n_state  = ST_PEAK;
            end
            ST_PEAK: begin
                o_cmd.op = OP_PEAK;
                n_state  = ST_TAIL;
            end
            ST_TAIL: begin
                if (i_sts.req == REQ_STOP) begin
                    o_cmd.op = OP_EMA_A_LO;
                    n_state  = ST_EA_HI;
                end else begin
                    o_cmd.op = OP_PRED;
                    n_sel    = 1'b1;
                    n_state  = r_sel ? ST_DONE : ST_STALE;
                end
            end
            ST_EA_HI: begin
                o_cmd.op = OP_EMA_A_HI;
                n_state  = ST_EB_LO;
            end
            ST_EB_LO: begin
                o_cmd.op = OP_EMA_B_LO;
                n_state  = ST_EB_HI;
            end
            ST_EB_HI: begin
                o_cmd.op = OP_EMA_B_HI;
                n_state  = ST_ESUM;
            end
            ST_ESUM: begin
                o_cmd.op = OP_EMA_SUM;
                n_state  = ST_AFIN;
            end
            ST_AFIN: begin
                o_cmd.op = OP_ADD_FIN;
                n_sel    = 1'b1;
                n_state  = r_sel ? ST_STOPEND : ST_LOADD;
            end
            ST_STOPEND: begin
                o_cmd.op = OP_STOP_END;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_pow_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POW && !i_sts.pow_done) |=> (r_state == ST_POW || r_state == ST_POWR))
        else $error("factor loop left early");
    a_second_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AFIN && !r_sel) |=> (r_state == ST_LOADD && r_sel))
        else $error("merged tracker sample skipped");
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_sts.div_last) |=> (r_state == ST_POW))
        else $error("divider did not hand over");

endmodule
`default_nettype wire

FILE: hdl/burst_length_predictor_core.sv
// Top level of the burst length predictor.
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    req_type[2:0], timestamp_us[47:0]
//  o_res     out  valid/ready    pred_burst_us[39:0], pred_merged_us[39:0],
//                                burst_active, merged_active
//  i_cfg_*   in   write enable   i_cfg_idx[2:0], i_cfg_data[31:0]
//
// One item at a time. Start, interrupt, clear and unknown codes are handled at dispatch.
// Each tracker decay loads the divider, runs the bit-serial divider (elapsed
// time over half-life), forms the fraction factor through the shared multiplier
// with its rounding, and then forms the headroom product; a query runs two
// decays, a stop two decays and two averages.
// Reset is synchronous, clears the event, tracker and controller state and loads the register defaults.
// A finished result waits in the output register; the next item is accepted
// then, and its own result holds until the previous one is taken.
`default_nettype none
module burst_length_predictor_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    blp_req_if.sink     i_req,
    blp_res_if.source   o_res,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data
);
    import blp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequence the work of each item
    blp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_req.ready = cmd.in_ready;

    // hold state, arithmetic and the result register
    blp_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req_type       (i_req.req_type),
        .i_timestamp_us   (i_req.timestamp_us),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_pred_burst_us  (o_res.pred_burst_us),
        .o_pred_merged_us (o_res.pred_merged_us),
        .o_burst_active   (o_res.burst_active),
        .o_merged_active  (o_res.merged_active)
    );

endmodule
`default_nettype wire

FILE: bench/burst_length_predictor_core_test.sv
// Self-checking bench of the burst length predictor: directed table, then random events.
`default_nettype none
module burst_length_predictor_core_test;
    import blp_pkg::*;

    localparam logic [47:0] VAL_MAX_C = 48'hFFFF_FFFF_FFFF;
    localparam logic [39:0] OUT_MAX_C = 40'hFF_FFFF_FFFF;
    localparam int LIMIT = 4000000;

    typedef struct packed {
        logic [39:0] burst;
        logic [39:0] merged;
        logic        b_act;
        logic        m_act;
    } t_answer;

    typedef struct {
        logic [2:0]  req;
        logic [47:0] ts;
        logic        typed;   // expected answer typed in the row
        t_answer     ans;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_idx = '0;
    logic [31:0] cfg_data = '0;

    blp_req_if req_ch ();
    blp_res_if res_ch ();

    burst_length_predictor_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_res(res_ch.source),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [31:0] gap_r, valid_r, hl_r;
    logic [15:0] alpha_r;
    logic [7:0]  cold_r;
    logic b_open, m_open, m_end_ok;
    logic [47:0] b_begin, m_begin, m_end;
    logic [47:0] trk_avg [2];
    logic [47:0] trk_peak [2];
    logic [7:0]  trk_cnt [2];
    logic [47:0] trk_ts [2];
    logic [47:0] trk_td [2];

    t_answer answers_due [$];
    bit failed = 0;
    int unsigned cyc = 0;
    int send_idle = 0, recv_stall = 0;
    logic [47:0] clock_us = 0;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT) begin
            $display("burst_length_predictor_core regression: fail");
            $finish;
        end
    end

    function automatic logic [47:0] elapsed(logic [47:0] now, logic [47:0] ref_t);
        return now > ref_t ? now - ref_t : 48'd0;
    endfunction

    function automatic logic [47:0] us_to_val(logic [47:0] us);
        if (us > (VAL_MAX_C >> 8)) return VAL_MAX_C;
        return us << 8;
    endfunction

    function automatic logic [63:0] fraction_factor(logic [7:0] f);
        logic [31:0] tbl [8];
        logic [95:0] acc;
        tbl = '{32'd4283353945, 32'd4271771996, 32'd4248701965, 32'd4202935003,
                32'd4112874773, 32'd3938502376, 32'd3611622603, 32'd3037000500};
        acc = 96'h1_0000_0000;
        for (int k = 0; k < 8; k++)
            if (f[k]) acc = (acc * tbl[k] + 96'h8000_0000) >> 32;
        return (acc + 96'h8000) >> 16;
    endfunction

    function automatic logic [47:0] shrink_headroom(logic [47:0] h, logic [47:0] el);
        logic [63:0] n, f;
        logic [127:0] p;
        n = el / hl_r;
        f = ((el % hl_r) << 8) / hl_r;
        if (n >= 48) return 48'd0;
        p = ({80'd0, h} * fraction_factor(f[7:0])) >> (16 + n);
        return p[47:0];
    endfunction

    function automatic void clear_tracker(int i);
        trk_avg[i] = 0; trk_peak[i] = 0; trk_cnt[i] = 0; trk_ts[i] = 0; trk_td[i] = 0;
    endfunction

    function automatic void decay_tracker(int i, logic [47:0] now);
        logic [47:0] a, p, el;
        a = trk_avg[i];
        p = trk_peak[i];
        if (trk_cnt[i] == 0 || hl_r == 0 || now <= trk_td[i]) return;
        el = now - trk_td[i];
        if (p >= a) p = a + shrink_headroom(p - a, el);
        else p = a - shrink_headroom(a - p, el);
        trk_peak[i] = p;
        trk_td[i] = now;
    endfunction

    function automatic void add_sample(int i, logic [47:0] d, logic [47:0] now);
        logic [80:0] s;
        decay_tracker(i, now);
        if (trk_cnt[i] == 0) trk_avg[i] = d;
        else begin
            s = 81'(alpha_r) * d + 81'(17'd65536 - alpha_r) * trk_avg[i] + 81'd32768;
            trk_avg[i] = 48'(s >> 16);
        end
        if (trk_cnt[i] < 255) trk_cnt[i]++;
        if (d > trk_peak[i]) trk_peak[i] = d;
        trk_ts[i] = now;
        trk_td[i] = now;
    endfunction

    function automatic logic [39:0] query_tracker(int i, logic [47:0] now);
        logic [48:0] v;
        if (trk_cnt[i] > 0 && elapsed(now, trk_ts[i]) > valid_r) clear_tracker(i);
        decay_tracker(i, now);
        if (trk_cnt[i] == 0) v = 0;
        else if (trk_cnt[i] < cold_r) v = trk_peak[i];
        else v = trk_avg[i] + (trk_peak[i] > trk_avg[i] ?
                               (trk_peak[i] - trk_avg[i]) / 2 : 0);
        v = v >> 8;
        return v > OUT_MAX_C ? OUT_MAX_C : v[39:0];
    endfunction

    function automatic t_answer predict_event(logic [2:0] req, logic [47:0] now);
        t_answer r;
        r = '0;
        case (req)
            REQ_START: if (!b_open) begin
                b_open = 1; b_begin = now;
                if (!m_open || !m_end_ok || elapsed(now, m_end) > gap_r) begin
                    m_open = 1; m_begin = now; m_end_ok = 0;
                end
            end
            REQ_STOP: begin
                if (b_open) begin
                    add_sample(0, us_to_val(elapsed(now, b_begin)), now);
                    m_end = now; m_end_ok = 1;
                    add_sample(1, us_to_val(elapsed(now, m_begin)), now);
                end
                b_open = 0;
            end
            REQ_INTR: begin b_open = 0; m_open = 0; m_end_ok = 0; end
            REQ_QUERY: begin
                r.burst = query_tracker(0, now);
                r.merged = query_tracker(1, now);
            end
            REQ_CLEAR: begin
                b_open = 0; m_open = 0; m_end_ok = 0;
                clear_tracker(0); clear_tracker(1);
            end
            default: ;
        endcase
        r.b_act = b_open;
        r.m_act = m_open;
        return r;
    endfunction

    task automatic reset_model();
        gap_r = 1000; valid_r = 3000000; hl_r = 500000; alpha_r = 19661; cold_r = 4;
        b_open = 0; m_open = 0; m_end_ok = 0; b_begin = 0; m_begin = 0; m_end = 0;
        clear_tracker(0); clear_tracker(1);
    endtask

    // result side: random stall, compare against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else begin
            if (res_ch.valid && res_ch.ready) begin
                if (answers_due.size() == 0) begin
                    $error("result with nothing expected");
                    failed = 1;
                end else begin
                    t_answer e;
                    e = answers_due.pop_front();
                    if (res_ch.pred_burst_us !== e.burst) begin
                        $error("pred_burst_us exp %0d got %0d", e.burst, res_ch.pred_burst_us);
                        failed = 1;
                    end
                    if (res_ch.pred_merged_us !== e.merged) begin
                        $error("pred_merged_us exp %0d got %0d", e.merged,
                               res_ch.pred_merged_us);
                        failed = 1;
                    end
                    if (res_ch.burst_active !== e.b_act) begin
                        $error("burst_active exp %0d got %0d", e.b_act, res_ch.burst_active);
                        failed = 1;
                    end
                    if (res_ch.merged_active !== e.m_act) begin
                        $error("merged_active exp %0d got %0d", e.m_act, res_ch.merged_active);
                        failed = 1;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // one write, then a quiet edge so the enable drops before the next write
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MERGE_GAP:  gap_r = val;
            CFG_VALID_TIME: valid_r = val;
            CFG_HALF_LIFE:  hl_r = val;
            CFG_ALPHA:      alpha_r = val[15:0];
            CFG_COLD_START: cold_r = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // drain every expected result, then let the block settle
    task automatic wait_idle();
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // present one item; hold valid across back-to-back items, drop it only when idling
    task automatic send_event(logic [2:0] req, logic [47:0] ts, logic typed, t_answer ans);
        t_answer p;
        while ($urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= req;
        req_ch.timestamp_us <= ts;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        p = predict_event(req, ts);
        if (typed && p !== ans) begin
            $error("table row disagrees with prediction for req %0d", req);
            failed = 1;
        end
        answers_due.push_back(p);
    endtask

    task automatic stop_sending();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // pick a plausible event: mostly start/stop pairs with advancing time
    task automatic random_event();
        int r;
        logic [2:0] rq;
        logic [47:0] ts;
        r = $urandom_range(99);
        clock_us = clock_us + $urandom_range(3000);
        if (r < 3) clock_us = clock_us + {$urandom, 16'd0};
        ts = clock_us;
        if (r < 38) rq = REQ_START;
        else if (r < 75) rq = REQ_STOP;
        else if (r < 90) rq = REQ_QUERY;
        else if (r < 93) rq = REQ_INTR;
        else if (r < 94) rq = REQ_CLEAR;
        else if (r < 96) rq = 3'($urandom_range(7));
        else begin
            rq = 3'($urandom_range(4));
            ts = {$urandom, $urandom} & VAL_MAX_C;   // time noise, often backward
        end
        send_event(rq, ts, 1'b0, '0);
    endtask

    t_row rows [$];

    initial begin
        t_answer z;
        z = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.timestamp_us = '0;
        reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows: answers typed where they follow at once
        rows.push_back('{REQ_QUERY, 48'd0, 1'b1, '{0, 0, 0, 0}});
        rows.push_back('{REQ_STOP, 48'd5, 1'b1, '{0, 0, 0, 0}});
        rows.push_back('{REQ_START, 48'd100, 1'b1, '{0, 0, 1, 1}});
        rows.push_back('{REQ_START, 48'd150, 1'b1, '{0, 0, 1, 1}});
        rows.push_back('{REQ_STOP, 48'd1100, 1'b1, '{0, 0, 0, 1}});
        rows.push_back('{REQ_QUERY, 48'd1100, 1'b1, '{1000, 1000, 0, 1}});
        rows.push_back('{REQ_START, 48'd1500, 1'b0, z});
        rows.push_back('{REQ_STOP, 48'd1400, 1'b0, z});
        rows.push_back('{REQ_START, 48'd2000, 1'b0, z});
        rows.push_back('{REQ_STOP, 48'd9000, 1'b0, z});
        rows.push_back('{REQ_QUERY, 48'd500000, 1'b0, z});
        rows.push_back('{REQ_QUERY, 48'd400000, 1'b0, z});
        rows.push_back('{3'd5, 48'd1, 1'b1, '{0, 0, 0, 1}});
        rows.push_back('{3'd7, VAL_MAX_C, 1'b1, '{0, 0, 0, 1}});
        rows.push_back('{REQ_INTR, 48'd9500, 1'b1, '{0, 0, 0, 0}});
        rows.push_back('{REQ_START, 48'd0, 1'b1, '{0, 0, 1, 1}});
        rows.push_back('{REQ_STOP, VAL_MAX_C, 1'b0, z});
        rows.push_back('{REQ_QUERY, VAL_MAX_C, 1'b0, z});
        rows.push_back('{3'd6, 48'd2, 1'b1, '{0, 0, 0, 1}});
        rows.push_back('{REQ_QUERY, 48'h8000_0000_0000, 1'b0, z});
        rows.push_back('{REQ_CLEAR, 48'd7, 1'b1, '{0, 0, 0, 0}});
        rows.push_back('{REQ_QUERY, 48'd8, 1'b1, '{0, 0, 0, 0}});
        foreach (rows[i]) send_event(rows[i].req, rows[i].ts, rows[i].typed, rows[i].ans);
        stop_sending();
        wait_idle();

        // phases: config settings crossed with idling modes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_reg(CFG_COLD_START, 0); write_reg(CFG_ALPHA, 16'hFFFF); end
                1: begin write_reg(CFG_HALF_LIFE, 1); write_reg(CFG_MERGE_GAP, 0);
                         write_reg(CFG_ALPHA, 0); write_reg(CFG_COLD_START, 255); end
                2: begin write_reg(CFG_HALF_LIFE, 32'hFFFF_FFFF);
                         write_reg(CFG_MERGE_GAP, 32'hFFFF_FFFF);
                         write_reg(CFG_VALID_TIME, 32'hFFFF_FFFF);
                         write_reg(CFG_COLD_START, 1); end
                3: begin write_reg(CFG_VALID_TIME, 0); write_reg(CFG_HALF_LIFE, 0); end
                default: begin
                    write_reg(CFG_MERGE_GAP, $urandom_range(4000));
                    write_reg(CFG_VALID_TIME, $urandom_range(10000, 5000000));
                    write_reg(CFG_HALF_LIFE, $urandom_range(1, 2000000));
                    write_reg(CFG_ALPHA, $urandom_range(65535));
                    write_reg(CFG_COLD_START, $urandom_range(1, 8));
                end
            endcase
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 72; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 72; end
                default: begin send_idle = 21; recv_stall = 21; end
            endcase
            for (int n = 0; n < 125; n++) begin
                random_event();
                if (n == 60) begin
                    // hold off until every result is home
                    stop_sending();
                    while (answers_due.size() != 0) @(posedge i_clk);
                end
            end
            stop_sending();
            wait_idle();
        end

        if (!failed)
            $display("burst_length_predictor_core regression: pass");
        else
            $display("burst_length_predictor_core regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

FILE: burst_length_predictor_core.f
hdl/blp_pkg.sv
hdl/blp_req_if.sv
hdl/blp_res_if.sv
hdl/blp_datapath.sv
hdl/blp_ctrl.sv
hdl/burst_length_predictor_core.sv
bench/burst_length_predictor_core_test.sv
